// ===== hw/rtl/qdd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdd_pkg
// Types and constants shared by the quadrature detent decoder modules.
// ----------------------------------------------------------------------------
package qdd_pkg;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_POLL   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // history after the last four pairs of a full clockwise / counterclockwise detent
  localparam logic [7:0] DETENT_UP   = 8'h4B;
  localparam logic [7:0] DETENT_DOWN = 8'h87;

  localparam logic signed [1:0] STEP_POS  = 2'sb01;
  localparam logic signed [1:0] STEP_NEG  = 2'sb11;
  localparam logic signed [1:0] STEP_ZERO = 2'sb00;

  typedef struct packed {
    logic [1:0] kind;
    logic       phase_a;
    logic       phase_b;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] step;
    logic              detent_seen;
  } out_item_t;

endpackage

// ===== hw/rtl/qdd_core.sv =====
// ----------------------------------------------------------------------------
// qdd_core
// Decoder state (last levels, phase history, pending-step counter) and the
// single-pass update that turns one item into its result.
// ----------------------------------------------------------------------------
module qdd_core #(
  parameter int COUNT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  qdd_pkg::in_item_t  item,
  input  logic               direction,
  output qdd_pkg::out_item_t result
);
  import qdd_pkg::*;

  localparam logic signed [COUNT_BITS-1:0] CNT_ONE  = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic signed [COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX  = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN  = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic                          last_a_r, last_a_nxt;
  logic                          last_b_r, last_b_nxt;
  logic [7:0]                    hist_r, hist_nxt;
  logic signed [COUNT_BITS-1:0]  pending_r, pending_nxt;

  logic       one_changed;
  logic [7:0] hist_shift;
  logic       both_high;
  logic       pend_pos;
  logic       pend_neg;

  assign one_changed = (item.phase_a ^ last_a_r) ^ (item.phase_b ^ last_b_r);
  assign hist_shift  = {hist_r[5:0], item.phase_a, item.phase_b};
  assign both_high   = item.phase_a & item.phase_b;
  assign pend_neg    = pending_r[COUNT_BITS-1];
  assign pend_pos    = !pending_r[COUNT_BITS-1] && (|pending_r);

  always_comb begin
    last_a_nxt         = last_a_r;
    last_b_nxt         = last_b_r;
    hist_nxt           = hist_r;
    pending_nxt        = pending_r;
    result.step        = STEP_ZERO;
    result.detent_seen = 1'b0;
    unique case (item.kind)
      KIND_SAMPLE: begin
        if (one_changed) begin
          last_a_nxt = item.phase_a;
          last_b_nxt = item.phase_b;
          hist_nxt   = hist_shift;
          if (both_high && hist_shift == DETENT_UP && pending_r != CNT_MAX) begin
            pending_nxt        = pending_r + CNT_ONE;
            result.detent_seen = 1'b1;
          end else if (both_high && hist_shift == DETENT_DOWN && pending_r != CNT_MIN) begin
            pending_nxt        = pending_r - CNT_ONE;
            result.detent_seen = 1'b1;
          end
        end
      end
      KIND_POLL: begin
        // drain one step toward zero; direction low flips the reported sign
        if (pend_pos) begin
          pending_nxt = pending_r - CNT_ONE;
          result.step = direction ? STEP_POS : STEP_NEG;
        end else if (pend_neg) begin
          pending_nxt = pending_r + CNT_ONE;
          result.step = direction ? STEP_NEG : STEP_POS;
        end
      end
      KIND_CLEAR: begin
        pending_nxt = CNT_ZERO;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r  <= 1'b0;
      last_b_r  <= 1'b0;
      hist_r    <= '0;
      pending_r <= CNT_ZERO;
    end else if (en) begin
      last_a_r  <= last_a_nxt;
      last_b_r  <= last_b_nxt;
      hist_r    <= hist_nxt;
      pending_r <= pending_nxt;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(pending_r) && $stable(hist_r))
    else $error("decoder state moved without an item");

  a_detent_only_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    result.detent_seen |-> item.kind == KIND_SAMPLE && result.step == STEP_ZERO)
    else $error("detent flagged on a non-sample item");

  a_poll_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (item.kind == KIND_POLL && pending_r == CNT_ZERO) |-> result.step == STEP_ZERO)
    else $error("poll drained a step from an empty counter");

endmodule

// ===== hw/rtl/quadrature_detent_decoder_top.sv =====
// Path: input beat to result beat through the input register, then the result register.
// One item per cycle while result beats are taken; the result register frees as its beat is taken.
// Reset (rst_n low, synchronous): pipeline emptied, levels, history and count cleared,
// direction set to 1.
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_top
// Two-phase rotary encoder detent decoder with poll/clear of pending steps.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder_top #(
  parameter int COUNT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qdd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output qdd_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import qdd_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      dir_r;
  logic      advance;
  out_item_t result;

  // result register can take a new beat when empty or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b1;
    end else if (cfg_wr_en) begin
      dir_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  qdd_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_valid_r && advance),
    .item      (s1_item_r),
    .direction (dir_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost a beat while stalled");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("advanced beat did not reach the result register");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

endmodule
